### rtl/json_escape_bounded_appender_macros.svh
// Assertion helpers for the appender RTL; clock and reset are the block's own.
`ifndef JSON_ESCAPE_BOUNDED_APPENDER_MACROS_SVH
`define JSON_ESCAPE_BOUNDED_APPENDER_MACROS_SVH

// Same-cycle implication.
`define JEBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define JEBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/jeba_pkg.sv
`default_nettype none
package jeba_pkg;

    localparam int LENGTH_BITS_DEF = 16;

    localparam logic [15:0] TOTAL_LIMIT_RST   = 16'd4096;
    localparam logic [15:0] BASE_CAPACITY_RST = 16'd256;
    localparam logic        GROWTH_RST        = 1'b1;
    localparam logic [15:0] TAIL_RESERVE_RST  = 16'd512;

    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Input modes
    localparam logic [1:0] MODE_RAW   = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_TOTAL_LIMIT   = 2'd0;
    localparam logic [1:0] REG_BASE_CAPACITY = 2'd1;
    localparam logic [1:0] REG_GROWTH        = 2'd2;
    localparam logic [1:0] REG_TAIL_RESERVE  = 2'd3;

    localparam int PIECE_MAX = 6;

    // One run of bytes produced by a single input word
    typedef struct packed {
        logic [PIECE_MAX-1:0][7:0] piece;
        logic [2:0]                cnt;
        logic [15:0]               start;
        logic                      trunc;
    } t_run;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10) begin
            d = 8'h30 + {4'd0, nib};
        end else begin
            d = 8'h57 + {4'd0, nib};
        end
        return d;
    endfunction

endpackage
`default_nettype wire

### rtl/json_escape_bounded_appender.sv
// A run is registered in the held stage (r_a) and then in the emitting stage (r_b).
// Throughput, output ready: one input word per cycle while each yields at most one
// byte; an escaped word yields up to six bytes, one per cycle via the single port.
// Reset (synchronous, active low) empties both stages, zeroes the fill length,
// clears the truncated and halted flags and loads the register defaults.
`default_nettype none
`include "json_escape_bounded_appender_macros.svh"
module json_escape_bounded_appender
    import jeba_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_starts_string,

    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [7:0]  o_out_byte,
    output logic      [15:0] o_out_position,
    output logic             o_last_of_run,
    output logic             o_truncated_now,
    output logic      [15:0] o_length_after
);

    localparam int LW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [LW-1:0] LenMax = LW'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [15:0] r_total_limit, r_base_capacity, r_tail_reserve;
    logic        r_growth;

    logic [LENGTH_BITS-1:0] r_fill, n_fill;
    logic                   r_trunc, n_trunc;
    logic                   r_halted, n_halted;

    t_run       r_a, n_a;
    logic       r_a_valid;
    t_run       r_b;
    logic       r_b_valid;
    logic [2:0] r_b_idx;

    logic                  cfg_wr;
    logic                  in_acc;
    logic [PIECE_MAX-1:0][7:0] piece;
    logic [2:0]            piece_n;
    logic [15:0]           lim16;
    logic [LW-1:0]         lim, fill_ext, room;
    logic                  fits;
    logic [2:0]            w;
    logic                  append;
    logic [15:0]           tail_gap;
    logic                  tail_fail;
    logic                  halted_eff;
    logic                  b_last, b_free, a_move;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_limit   <= TOTAL_LIMIT_RST;
            r_base_capacity <= BASE_CAPACITY_RST;
            r_growth        <= GROWTH_RST;
            r_tail_reserve  <= TAIL_RESERVE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_TOTAL_LIMIT:   r_total_limit   <= pwdata[15:0];
                REG_BASE_CAPACITY: r_base_capacity <= pwdata[15:0];
                REG_GROWTH:        r_growth        <= pwdata[0];
                REG_TAIL_RESERVE:  r_tail_reserve  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_TOTAL_LIMIT:   prdata = {16'd0, r_total_limit};
            REG_BASE_CAPACITY: prdata = {16'd0, r_base_capacity};
            REG_GROWTH:        prdata = {31'd0, r_growth};
            REG_TAIL_RESERVE:  prdata = {16'd0, r_tail_reserve};
            default:           prdata = '0;
        endcase
    end

    jeba_escape u_escape (
        .i_esc   (i_mode == MODE_ESC),
        .i_byte  (i_in_byte),
        .o_piece (piece),
        .o_count (piece_n)
    );

    // Room left under the effective limit
    always_comb begin
        lim16 = r_total_limit;
        if (!r_growth && (r_base_capacity < r_total_limit)) begin
            lim16 = r_base_capacity;
        end
        lim = LW'(lim16);
        if (lim > LenMax) begin
            lim = LenMax;
        end
        fill_ext = LW'(r_fill);
        room     = (lim > fill_ext) ? (lim - fill_ext) : '0;
        fits     = room >= LW'(piece_n);
        w        = fits ? piece_n : room[2:0];
        tail_gap = r_total_limit - r_tail_reserve;
        tail_fail = (r_total_limit > r_tail_reserve) && (fill_ext >= LW'(tail_gap));
        halted_eff = r_halted && !i_starts_string;
    end

    assign in_acc = i_in_valid && o_in_ready;

    // State update for one accepted word
    always_comb begin
        n_fill   = r_fill;
        n_trunc  = r_trunc;
        n_halted = r_halted;
        append   = 1'b0;
        case (i_mode)
            MODE_RAW: begin
                append = 1'b1;
            end
            MODE_ESC: begin
                n_halted = halted_eff;
                if (halted_eff) begin
                    append = 1'b0;
                end else if (i_in_byte == 8'h00) begin
                    n_halted = 1'b1;
                end else if (tail_fail) begin
                    n_trunc  = 1'b1;
                    n_halted = 1'b1;
                end else begin
                    append = 1'b1;
                    if (r_trunc || !fits) begin
                        n_halted = 1'b1;
                    end
                end
            end
            MODE_CLEAR: begin
                n_fill  = '0;
                n_trunc = 1'b0;
            end
            default: ;
        endcase
        if (append) begin
            n_fill = LENGTH_BITS'(fill_ext + LW'(w));
            if (!fits) begin
                n_trunc = 1'b1;
            end
        end
        n_a.piece = piece;
        n_a.cnt   = w;
        n_a.start = 16'(fill_ext);
        n_a.trunc = n_trunc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_trunc  <= 1'b0;
            r_halted <= 1'b0;
        end else if (in_acc) begin
            r_fill   <= n_fill;
            r_trunc  <= n_trunc;
            r_halted <= n_halted;
        end
    end

    // Hand-off between the held run and the emitting run
    assign b_last     = r_b_valid && (r_b_idx == (r_b.cnt - 3'd1));
    assign b_free     = !r_b_valid || (i_out_ready && b_last);
    assign a_move     = r_a_valid && b_free;
    assign o_in_ready = !r_a_valid || b_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc && append && (w != 3'd0)) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && append && (w != 3'd0)) begin
            r_a <= n_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
            r_b_idx   <= '0;
        end else if (r_b_valid && i_out_ready) begin
            if (b_last) begin
                r_b_valid <= 1'b0;
            end else begin
                r_b_idx <= r_b_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b <= r_a;
        end
    end

    assign o_out_valid     = r_b_valid;
    assign o_out_byte      = r_b.piece[r_b_idx];
    assign o_out_position  = r_b.start + {13'd0, r_b_idx};
    assign o_last_of_run   = b_last;
    assign o_truncated_now = r_b.trunc;
    assign o_length_after  = r_b.start + {13'd0, r_b_idx} + 16'd1;

    `JEBA_ASSERT_NOW(a_held_run_nonempty, r_a_valid, (r_a.cnt != 3'd0) && (r_a.cnt <= 3'd6), "held run has a bad byte count")
    `JEBA_ASSERT_NOW(b_index_in_run, r_b_valid, (r_b_idx < r_b.cnt) && (r_b.cnt <= 3'd6), "emit index outside its run")
    `JEBA_ASSERT_NEXT(b_position_advances, o_out_valid && i_out_ready && !o_last_of_run, o_out_valid && (o_out_position == 16'($past(o_out_position) + 16'd1)), "byte position did not advance within a run")
    `JEBA_ASSERT_NEXT(b_drains_when_idle, o_out_valid && i_out_ready && o_last_of_run && !r_a_valid, !o_out_valid, "output stayed valid with no pending run")

endmodule
`default_nettype wire

### rtl/jeba_escape.sv
`default_nettype none
module jeba_escape
    import jeba_pkg::*;
(
    input  wire logic                      i_esc,
    input  wire logic [7:0]                i_byte,
    output logic      [PIECE_MAX-1:0][7:0] o_piece,
    output logic      [2:0]                o_count
);

    localparam logic [7:0] ChQuote = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChNl = 8'h0A;
    localparam logic [7:0] ChCr = 8'h0D;
    localparam logic [7:0] ChTab = 8'h09;
    localparam logic [7:0] ChBs = 8'h08;
    localparam logic [7:0] ChFf = 8'h0C;

    logic [7:0] short_code;

    always_comb begin
        case (i_byte)
            ChQuote:  short_code = ChQuote;
            ChBslash: short_code = ChBslash;
            ChNl:     short_code = 8'h6E;
            ChCr:     short_code = 8'h72;
            ChTab:    short_code = 8'h74;
            ChBs:     short_code = 8'h62;
            ChFf:     short_code = 8'h66;
            default:  short_code = 8'h00;
        endcase
    end

    always_comb begin
        o_piece    = '0;
        o_piece[0] = i_byte;
        o_count    = 3'd1;
        if (i_esc) begin
            if (short_code != 8'h00) begin
                o_piece[0] = ChBslash;
                o_piece[1] = short_code;
                o_count    = 3'd2;
            end else if (i_byte < CTRL_LIMIT) begin
                o_piece[0] = ChBslash;
                o_piece[1] = 8'h75;
                o_piece[2] = 8'h30;
                o_piece[3] = 8'h30;
                o_piece[4] = hex_digit(i_byte[7:4]);
                o_piece[5] = hex_digit(i_byte[3:0]);
                o_count    = 3'd6;
            end
        end
    end

endmodule
`default_nettype wire
